// File: design/sjtm_pkg.sv
package sjtm_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned TOL_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LEN_FROM_POS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_TOL      = 2'd1;

  localparam logic             LEN_FROM_POS_RESET = 1'b1;
  localparam logic [TOL_W-1:0] POS_TOL_RESET      = 16'd5;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [1:0] {
    OP_APPEND,
    OP_DROP,
    OP_QUERY
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] span;
    logic [DATA_W-1:0] first;
    logic [DATA_W-1:0] second;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] span;
    logic [DATA_W-1:0] first;
    logic [DATA_W-1:0] second;
  } entry_t;

  typedef struct packed {
    logic             length_from_positions;
    logic [TOL_W-1:0] position_tolerance;
  } cfg_t;

  function automatic logic [DATA_W-1:0] abs_diff(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

// File: design/sjtm_if.sv
interface sjtm_in_if import sjtm_pkg::*;;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [DATA_W-1:0] span_length;
  logic [DATA_W-1:0] pos_first;
  logic [DATA_W-1:0] pos_second;

  modport source (output valid, output kind, output span_length, output pos_first,
                  output pos_second, input ready);
  modport sink (input valid, input kind, input span_length, input pos_first,
                input pos_second, output ready);
endinterface

interface sjtm_out_if;
  logic valid;
  logic ready;
  logic result_kind;
  logic novel;
  logic load_dropped;

  modport source (output valid, output result_kind, output novel, output load_dropped,
                  input ready);
  modport sink (input valid, input result_kind, input novel, input load_dropped,
                output ready);
endinterface

// File: design/sjtm_front.sv
module sjtm_front import sjtm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sjtm_in_if.sink     in_i,
  input  cfg_t        cfg_i,
  output logic        push_valid_o,
  output cmd_t        push_cmd_o,
  input  logic        push_ready_i
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             table_full;
  logic             fire;

  assign table_full   = (count_q == CNT_W'(TABLE_DEPTH));
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign fire         = in_i.valid && push_ready_i;

  always_comb begin
    push_cmd_o.first  = in_i.pos_first;
    push_cmd_o.second = in_i.pos_second;
    push_cmd_o.span   = in_i.span_length;
    if (in_i.kind == KIND_QUERY) begin
      push_cmd_o.op = OP_QUERY;
      if (cfg_i.length_from_positions) begin
        push_cmd_o.span = abs_diff(in_i.pos_second, in_i.pos_first);
      end
    end else begin
      push_cmd_o.op = table_full ? OP_DROP : OP_APPEND;
    end
  end

  always_comb begin
    count_d = count_q;
    if (fire && in_i.kind == KIND_LOAD && !table_full) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

// File: design/sjtm_queue.sv
module sjtm_queue import sjtm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  cmd_t push_cmd_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output cmd_t pop_cmd_o,
  input  logic pop_ready_i
);

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] fill_q, fill_d;
  logic              push, pop;

  assign push_ready_o = (fill_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_cmd_o    = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + QCNT_W'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

// File: design/sjtm_back.sv
module sjtm_back import sjtm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        pop_valid_i,
  input  cmd_t        pop_cmd_i,
  output logic        pop_ready_o,
  sjtm_out_if.source  out_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  cmp_idx_q, cmp_idx_d;
  logic [IDX_W-1:0]  rd_addr;
  cmd_t              qry_q, qry_d;
  logic              novel_q, novel_d;
  entry_t            mem [TABLE_DEPTH];
  entry_t            rd_q;
  entry_t            wdata;
  logic              mem_we;
  logic              out_free;
  logic              pop_fire;
  logic              hit, last;
  logic [DATA_W-1:0] tol;

  logic out_valid_q, out_valid_d;
  logic out_kind_q, out_kind_d;
  logic out_novel_q, out_novel_d;
  logic out_drop_q, out_drop_d;

  assign out_free    = !out_valid_q || out_o.ready;
  assign pop_ready_o = (state_q == S_IDLE) && out_free;
  assign pop_fire    = pop_valid_i && pop_ready_o;
  assign tol         = {{(DATA_W - TOL_W){1'b0}}, cfg_i.position_tolerance};

  assign wdata.span   = pop_cmd_i.span;
  assign wdata.first  = pop_cmd_i.first;
  assign wdata.second = pop_cmd_i.second;

  assign hit  = (rd_q.span == qry_q.span) &&
                (abs_diff(qry_q.first, rd_q.first) <= tol) &&
                (abs_diff(qry_q.second, rd_q.second) <= tol);
  assign last = (CNT_W'(cmp_idx_q) + CNT_W'(1) == cnt_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmp_idx_d   = cmp_idx_q;
    qry_d       = qry_q;
    novel_d     = novel_q;
    mem_we      = 1'b0;
    rd_addr     = cmp_idx_q + IDX_W'(1);
    out_valid_d = out_valid_q && !out_o.ready;
    out_kind_d  = out_kind_q;
    out_novel_d = out_novel_q;
    out_drop_d  = out_drop_q;
    unique case (state_q)
      S_IDLE: begin
        if (pop_fire) begin
          case (pop_cmd_i.op)
            OP_APPEND: begin
              mem_we      = 1'b1;
              cnt_d       = cnt_q + CNT_W'(1);
              out_valid_d = 1'b1;
              out_kind_d  = KIND_LOAD;
              out_novel_d = 1'b0;
              out_drop_d  = 1'b0;
            end
            OP_DROP: begin
              out_valid_d = 1'b1;
              out_kind_d  = KIND_LOAD;
              out_novel_d = 1'b0;
              out_drop_d  = 1'b1;
            end
            OP_QUERY: begin
              if (cnt_q == '0) begin
                out_valid_d = 1'b1;
                out_kind_d  = KIND_QUERY;
                out_novel_d = 1'b1;
                out_drop_d  = 1'b0;
              end else begin
                qry_d     = pop_cmd_i;
                rd_addr   = '0;
                cmp_idx_d = '0;
                state_d   = S_SCAN;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (hit || last) begin
          novel_d = !hit;
          state_d = S_DONE;
        end else begin
          cmp_idx_d = cmp_idx_q + IDX_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = KIND_QUERY;
          out_novel_d = novel_q;
          out_drop_d  = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cnt_q[IDX_W-1:0]] <= wdata;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q   <= cmp_idx_d;
    qry_q       <= qry_d;
    novel_q     <= novel_d;
    out_kind_q  <= out_kind_d;
    out_novel_q <= out_novel_d;
    out_drop_q  <= out_drop_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_kind  = out_kind_q;
  assign out_o.novel        = out_novel_q;
  assign out_o.load_dropped = out_drop_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> (cnt_q != '0) && (CNT_W'(cmp_idx_q) < cnt_q))
    else $error("scan index outside loaded entries");

  a_append_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("append did not advance entry count");

  a_result_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_fire |-> out_free)
    else $error("command taken while result slot occupied");

endmodule

// File: design/splice_junction_tolerance_match.sv
// Channel   Modport  Transaction
// in_i      sink     kind, span_length, pos_first, pos_second
// out_o     source   result_kind, novel, load_dropped
// cfg_*     write    register index, data (no read-back)
//
// Load: appended to table memory, or dropped when full. Query: entries scanned
// one per cycle from the table memory read port, up to a match or the last entry.
// Front accepts one transaction per cycle while the two-entry queue has room.
// Reset clears counts, queue and output valid; table memory is not cleared.
// A stalled output holds the back end; the front keeps filling the queue.
module splice_junction_tolerance_match import sjtm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sjtm_in_if.sink               in_i,
  sjtm_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LEN_FROM_POS: cfg_d.length_from_positions = cfg_data_i[0];
        CFG_POS_TOL:      cfg_d.position_tolerance    = cfg_data_i[TOL_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.length_from_positions <= LEN_FROM_POS_RESET;
      cfg_q.position_tolerance    <= POS_TOL_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sjtm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_q),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  sjtm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_ready_i  (pop_ready)
  );

  sjtm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_cmd_i   (pop_cmd),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule
